/* hw/rtl/gtun_pkg.sv */
`default_nettype none
package gtun_pkg;

  localparam int GRAD_W             = 16;
  localparam int GRAD_FRAC_BITS_DEF = 8;
  localparam int OUT_FRAC_BITS      = 15;
  localparam int Q_W                = OUT_FRAC_BITS + 1;
  localparam int NUM_LANES          = 3;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } gtun_in_t;

  typedef struct packed {
    logic signed [OUT_FRAC_BITS:0] normal_x;
    logic signed [OUT_FRAC_BITS:0] normal_y;
    logic [OUT_FRAC_BITS-1:0]      normal_z;
  } gtun_out_t;

endpackage
`default_nettype wire

/* hw/rtl/gtun_step.sv */
`default_nettype none
module gtun_step import gtun_pkg::*; #(
  parameter int W = 69,
  parameter int K = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] s_i,
  input  wire logic signed [W-1:0] s3_i,
  input  wire logic signed [W-1:0] d_i,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic [Q_W-1:0]      q_i,
  output logic signed [W-1:0]      d_o,
  output logic signed [W-1:0]      a_o,
  output logic [Q_W-1:0]           q_o
);

  logic signed [W-1:0] diff;
  logic                acc;
  logic signed [W-1:0] d_nxt;
  logic signed [W-1:0] a_nxt;
  logic [Q_W-1:0]      q_nxt;
  logic signed [W-1:0] d_r;
  logic signed [W-1:0] a_r;
  logic [Q_W-1:0]      q_r;

  // The residual holds the target minus (2q-1)^2 * s; the trial bit is kept when it stays
  // non-negative.
  always_comb begin
    diff  = d_i - (a_i <<< (K + 2));
    acc   = ~diff[W-1];
    d_nxt = acc ? diff : d_i;
    q_nxt = acc ? (q_i | (Q_W'(1) << K)) : q_i;
  end

  generate
    if (K > 0) begin : g_next_a
      assign a_nxt = acc ? (a_i + (s3_i <<< (K - 1))) : (a_i - (s_i <<< (K - 1)));
    end else begin : g_last_a
      assign a_nxt = a_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      a_r <= a_nxt;
      q_r <= q_nxt;
    end
  end

  assign d_o = d_r;
  assign a_o = a_r;
  assign q_o = q_r;

endmodule
`default_nettype wire

/* hw/rtl/gradient_to_unit_normal.sv */
// Throughput: one transfer per cycle while the pipeline is not held; the three components
// each run one result bit per pipeline stage of the square root divide, so the stage count
// follows OUT_FRAC_BITS. The pipeline holds only while its last stage is full and the
// output register is stalled. Reset clears the valid bits of every stage and of the output
// register; data is not reset.
`default_nettype none
module gradient_to_unit_normal import gtun_pkg::*; #(
  parameter int GRAD_FRAC_BITS = GRAD_FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire gtun_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output gtun_out_t      out_data
);

  localparam int SQ_W     = 2 * GRAD_W;
  localparam int ONE_SQ_W = 2 * GRAD_FRAC_BITS + 1;
  localparam int S_W      = ((SQ_W > ONE_SQ_W) ? SQ_W : ONE_SQ_W) + 1;
  localparam int W        = S_W + 2 * OUT_FRAC_BITS + 6;
  localparam int R_SH     = 2 * OUT_FRAC_BITS + 2;
  localparam int NST      = Q_W;
  localparam int NS       = 3 + NST;
  localparam int LX       = 0;
  localparam int LY       = 1;
  localparam int LZ       = 2;

  localparam logic [S_W-1:0] ONE_SQ = S_W'(1) << (2 * GRAD_FRAC_BITS);
  localparam logic [W-1:0]   R_Z    = W'(1) << (2 * GRAD_FRAC_BITS + R_SH);

  logic [NS-1:0] st_v_r;
  logic          out_valid_r;
  gtun_out_t     out_data_r;
  logic          out_ld;
  logic          pipe_en;

  logic [GRAD_W-1:0] gx_u;
  logic [GRAD_W-1:0] gy_u;
  logic [GRAD_W-1:0] mag_x;
  logic [GRAD_W-1:0] mag_y;
  logic [SQ_W-1:0]   sq_x_nxt;
  logic [SQ_W-1:0]   sq_y_nxt;

  logic [SQ_W-1:0] sq_x1_r;
  logic [SQ_W-1:0] sq_y1_r;
  logic            pos_x1_r;
  logic            pos_y1_r;

  logic [SQ_W-1:0] sq_x2_r;
  logic [SQ_W-1:0] sq_y2_r;
  logic [S_W-1:0]  s2_r;
  logic            pos_x2_r;
  logic            pos_y2_r;

  logic signed [W-1:0] s_w;
  logic [W-1:0]        r_l [NUM_LANES];
  logic signed [W-1:0] d3_r [NUM_LANES];
  logic signed [W-1:0] a3_r;

  logic signed [W-1:0] sb_s_r  [NST+1];
  logic signed [W-1:0] sb_s3_r [NST+1];
  logic                sb_z_r  [NST+1];
  logic                sb_px_r [NST+1];
  logic                sb_py_r [NST+1];

  wire signed [W-1:0] ln_d [NUM_LANES][NST+1];
  wire signed [W-1:0] ln_a [NUM_LANES][NST+1];
  wire [Q_W-1:0]      ln_q [NUM_LANES][NST+1];

  logic [OUT_FRAC_BITS-1:0] mag_l [NUM_LANES];
  logic [Q_W-1:0]           sx;
  logic [Q_W-1:0]           sy;
  gtun_out_t                out_nxt;

  assign out_ld   = !out_valid_r || !out_stall;
  assign pipe_en  = out_ld || !st_v_r[NS-1];
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pipe_en) begin
        st_v_r <= {st_v_r[NS-2:0], in_valid};
      end
      if (out_ld) begin
        out_valid_r <= st_v_r[NS-1];
      end
    end
  end

  always_comb begin
    gx_u     = in_data.grad_x;
    gy_u     = in_data.grad_y;
    mag_x    = gx_u[GRAD_W-1] ? (~gx_u + GRAD_W'(1)) : gx_u;
    mag_y    = gy_u[GRAD_W-1] ? (~gy_u + GRAD_W'(1)) : gy_u;
    sq_x_nxt = SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y_nxt = SQ_W'(mag_y) * SQ_W'(mag_y);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_x1_r  <= sq_x_nxt;
      sq_y1_r  <= sq_y_nxt;
      pos_x1_r <= !gx_u[GRAD_W-1] && (gx_u != '0);
      pos_y1_r <= !gy_u[GRAD_W-1] && (gy_u != '0);

      sq_x2_r  <= sq_x1_r;
      sq_y2_r  <= sq_y1_r;
      s2_r     <= S_W'(sq_x1_r) + S_W'(sq_y1_r) + ONE_SQ;
      pos_x2_r <= pos_x1_r;
      pos_y2_r <= pos_y1_r;
    end
  end

  // The search for each component starts from q = 0, that is from the odd factor -1.
  always_comb begin
    s_w       = $signed(W'(s2_r));
    r_l[LX]   = W'(sq_x2_r) << R_SH;
    r_l[LY]   = W'(sq_y2_r) << R_SH;
    r_l[LZ]   = R_Z;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        d3_r[l] <= $signed(r_l[l]) - s_w;
      end
      a3_r       <= (s_w <<< OUT_FRAC_BITS) - s_w;
      sb_s_r[0]  <= s_w;
      sb_s3_r[0] <= s_w + (s_w <<< 1);
      sb_z_r[0]  <= (s2_r == '0);
      sb_px_r[0] <= pos_x2_r;
      sb_py_r[0] <= pos_y2_r;
    end
  end

  genvar gi, gl;
  generate
    for (gi = 1; gi <= NST; gi++) begin : g_side
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          sb_s_r[gi]  <= sb_s_r[gi-1];
          sb_s3_r[gi] <= sb_s3_r[gi-1];
          sb_z_r[gi]  <= sb_z_r[gi-1];
          sb_px_r[gi] <= sb_px_r[gi-1];
          sb_py_r[gi] <= sb_py_r[gi-1];
        end
      end
    end

    for (gl = 0; gl < NUM_LANES; gl++) begin : g_lane
      assign ln_d[gl][0] = d3_r[gl];
      assign ln_a[gl][0] = a3_r;
      assign ln_q[gl][0] = '0;
      for (gi = 1; gi <= NST; gi++) begin : g_stage
        gtun_step #(
          .W (W),
          .K (NST - gi)
        ) u_step (
          .clk  (clk),
          .en   (pipe_en),
          .s_i  (sb_s_r[gi-1]),
          .s3_i (sb_s3_r[gi-1]),
          .d_i  (ln_d[gl][gi-1]),
          .a_i  (ln_a[gl][gi-1]),
          .q_i  (ln_q[gl][gi-1]),
          .d_o  (ln_d[gl][gi]),
          .a_o  (ln_a[gl][gi]),
          .q_o  (ln_q[gl][gi])
        );
      end
    end
  endgenerate

  // A rounded magnitude of 1.0 saturates to the largest code below it.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag_l[l] = ln_q[l][NST][OUT_FRAC_BITS] ? '1 : ln_q[l][NST][OUT_FRAC_BITS-1:0];
    end
    sx = {1'b0, mag_l[LX]};
    sy = {1'b0, mag_l[LY]};
    if (sb_z_r[NST]) begin
      out_nxt = '0;
    end else begin
      out_nxt.normal_x = sb_px_r[NST] ? $signed(~sx + Q_W'(1)) : $signed(sx);
      out_nxt.normal_y = sb_py_r[NST] ? $signed(~sy + Q_W'(1)) : $signed(sy);
      out_nxt.normal_z = mag_l[LZ];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_full_tail: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && st_v_r[NS-1]))
    else $error("input stalled while the pipeline tail could move");

  a_tail_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (st_v_r[NS-1] && out_ld) |=> out_valid_r)
    else $error("a finished item did not reach the output register");

  a_norm_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r[2] |-> !sb_z_r[0])
    else $error("zero norm reached the square root pipeline");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import gtun_pkg::*;

  localparam int LATENCY      = OUT_FRAC_BITS + 5;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 400000;

  class normal_board;
    gtun_out_t expected_normals[$];
    int        errors;
    int        matched;

    function logic [OUT_FRAC_BITS-1:0] scaled_magnitude(longint num, longint ssq);
      longint       lo;
      longint       hi;
      longint       mid;
      longint       maxv;
      logic [127:0] odd;
      logic [127:0] lhs;
      logic [127:0] rhs;
      lo   = 0;
      hi   = longint'(1) << OUT_FRAC_BITS;
      maxv = hi - 1;
      rhs  = 128'(2 * num) * 128'(2 * num);
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        odd = 128'(2 * mid - 1);
        lhs = odd * odd * 128'(ssq);
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      if (lo > maxv) begin
        lo = maxv;
      end
      return lo[OUT_FRAC_BITS-1:0];
    endfunction

    function gtun_out_t unit_normal(gtun_in_t g);
      longint    mx;
      longint    my;
      longint    one;
      longint    ssq;
      longint    comp;
      gtun_out_t r;
      mx   = longint'(g.grad_x);
      my   = longint'(g.grad_y);
      one  = longint'(1) << GRAD_FRAC_BITS_DEF;
      mx   = (mx < 0) ? -mx : mx;
      my   = (my < 0) ? -my : my;
      ssq  = mx * mx + my * my + one * one;
      // The normal points against the gradient, so a positive slope gives a negative component.
      comp = longint'(scaled_magnitude(mx << OUT_FRAC_BITS, ssq));
      if (!g.grad_x[GRAD_W-1] && mx != 0) begin
        comp = -comp;
      end
      r.normal_x = comp[Q_W-1:0];
      comp = longint'(scaled_magnitude(my << OUT_FRAC_BITS, ssq));
      if (!g.grad_y[GRAD_W-1] && my != 0) begin
        comp = -comp;
      end
      r.normal_y = comp[Q_W-1:0];
      r.normal_z = scaled_magnitude(one << OUT_FRAC_BITS, ssq);
      return r;
    endfunction

    function void note_gradient(gtun_in_t g);
      expected_normals.push_back(unit_normal(g));
    endfunction

    function void check_normal(gtun_out_t got);
      gtun_out_t want;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 got.normal_x, got.normal_y, got.normal_z);
        errors++;
        return;
      end
      want = expected_normals.pop_front();
      if (got.normal_x !== want.normal_x) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z, got.normal_z);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  gtun_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  gtun_out_t out_data;

  normal_board board;
  bit          tx_steady;
  bit          rx_steady;
  int          cycles = 0;
  int          sent;

  gradient_to_unit_normal DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish in time", $time);
      $display("** gradient_to_unit_normal: FAILED **");
      $finish;
    end
  end

  task automatic send_gradient(gtun_in_t g);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_gradient(g);
    sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_normals.size() != 0) @(posedge clk);
  endtask

  function automatic logic [GRAD_W-1:0] pick_component();
    logic [GRAD_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = GRAD_W'($urandom_range(0, 2047) - 1024);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = GRAD_W'($urandom());
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed[$];
    gtun_in_t    g;
    sent      = 0;
    tx_steady = 1'b0;
    board     = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    directed = '{32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000,
                 32'h8000_7FFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
                 32'h0000_FFFF, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0100,
                 32'h0000_8000, 32'h8000_0000, 32'h7FFF_0000, 32'h0000_7FFF,
                 32'h0001_0001, 32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555,
                 32'h7FFF_0001, 32'h8001_FFFF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_gradient(gtun_in_t'(directed[i]));
    end
    hold_until_drained();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) begin
        hold_until_drained();
      end
      g.grad_x = pick_component();
      g.grad_y = pick_component();
      send_gradient(g);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d gradients (extremes, unit slopes, saturating cases, random mix).",
             sent);
    $display("Checked %0d normals under random sender gaps and receiver stalls.",
             board.matched);
    if (board.errors == 0 && board.expected_normals.size() == 0) begin
      $display("** gradient_to_unit_normal: PASSED **");
    end else begin
      $display("** gradient_to_unit_normal: FAILED **");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    int taken;
    rx_steady = 1'b0;
    taken     = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 90 == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      wait_cycles = rx_steady ? 0 : $urandom_range(0, 12);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_normal(out_data);
      taken++;
    end
  end

endmodule
